### src/assert_macros.svh
// Assertion helpers used by the checker module of this block.
// Each macro asserts one property on the rising edge of the given clock,
// switched off while the given reset is high, and reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain concurrent assertion with reset qualification.
`define SPS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Assertion that an antecedent implies a consequent in the next cycle.
`define SPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg: shared types and constants of the stepper phase sequencer
// Field widths, command codes, run states, the controller state type and
// the coil pattern lookup used by the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sps_pkg;

  // Tick rate and phase ring.
  localparam int TICKS_PER_SECOND = 1000;
  localparam int PHASE_COUNT      = 8;
  localparam int PHASE_W          = $clog2(PHASE_COUNT);

  // Field widths.
  localparam int OP_W     = 3;
  localparam int MODE_W   = 2;
  localparam int COUNT_W  = 15;
  localparam int SPEED_W  = 10;
  localparam int PERIOD_W = 10;
  localparam int MS_W     = 10;
  localparam int COIL_W   = 4;
  localparam int TABLE_W  = PHASE_COUNT * COIL_W;
  localparam int CFG_IDX_W = 1;

  // Limits and reset values.
  localparam int SPEED_MAX    = 1000;
  localparam int PERIOD_MAX   = 1023;
  localparam int PERIOD_RESET = 1000;
  localparam logic [TABLE_W-1:0] PHASE_TABLE_RESET = 32'h98C4_6231;
  localparam logic [COIL_W-1:0]  OFF_PATTERN_RESET = '0;

  // Serial divider sizing: the dividend is the tick rate.
  localparam int TPS_W    = $clog2(TICKS_PER_SECOND + 1);
  localparam int QUO_W    = (TPS_W > PERIOD_W) ? TPS_W : PERIOD_W;
  localparam int DIV_CNT_W = $clog2(QUO_W);
  localparam logic [QUO_W-1:0] TPS_VEC = QUO_W'(TICKS_PER_SECOND);

  // Command codes.
  typedef enum logic [OP_W-1:0] {
    OP_TICK         = 3'd0,
    OP_SET_MODE     = 3'd1,
    OP_TURN_COUNTED = 3'd2,
    OP_TURN_ENDLESS = 3'd3,
    OP_STOP         = 3'd4,
    OP_CONTINUE     = 3'd5
  } op_t;

  // Step modes; UNSET does not advance the phase.
  typedef enum logic [MODE_W-1:0] {
    MODE_WAVE  = 2'd0,
    MODE_FULL  = 2'd1,
    MODE_HALF  = 2'd2,
    MODE_UNSET = 2'd3
  } mode_t;

  // Stop selector.
  localparam logic [MODE_W-1:0] STOP_FREE = 2'd0;

  typedef enum logic [1:0] {
    RUN_FREE    = 2'd0,
    RUN_TORQUE  = 2'd1,
    RUN_TURNING = 2'd2
  } run_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_TABLE = 1'b0,
    CFG_OFF_PATTERN = 1'b1
  } cfg_idx_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_EMIT = 2'd2
  } ctrl_state_t;

  // Command transaction payload.
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [MODE_W-1:0]  mode_value;
    logic [COUNT_W-1:0] step_count;
    logic [SPEED_W-1:0] speed;
    logic               direction;
  } cmd_t;

  // Result transaction payload.
  typedef struct packed {
    logic [COIL_W-1:0] coils;
    logic              coils_updated;
    logic              moving;
  } res_t;

  // Divider request and response.
  typedef struct packed {
    logic               start;
    logic [SPEED_W-1:0] speed;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [PERIOD_W-1:0] period;
  } div_rsp_t;

  // Coil pattern of one phase out of the packed table.
  function automatic logic [COIL_W-1:0] pattern_of(input logic [TABLE_W-1:0] tbl,
                                                   input logic [PHASE_W-1:0] idx);
    pattern_of = tbl[{idx, 2'b00} +: COIL_W];
  endfunction

endpackage

`default_nettype wire

### src/sps_div.sv
// ----------------------------------------------------------------------------
// sps_div: serial step period divider
// Restoring division of the tick rate by the clamped speed, one quotient
// bit per cycle, with the quotient saturated to the period range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sps_div
  import sps_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                 active;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [SPEED_W-1:0]   rem;
  logic [QUO_W-1:0]     quo;
  logic [SPEED_W-1:0]   dvs;
  logic [SPEED_W-1:0]   speed_clamped;
  logic [SPEED_W:0]     rem_shift;
  logic [SPEED_W:0]     rem_diff;
  logic                 fits;

  // Speed is limited to one step per second up to the maximum rate.
  always_comb begin
    if (req.speed == '0) begin
      speed_clamped = SPEED_W'(1);
    end else if (req.speed > SPEED_W'(SPEED_MAX)) begin
      speed_clamped = SPEED_W'(SPEED_MAX);
    end else begin
      speed_clamped = req.speed;
    end
  end

  // One restoring step: bring down the next dividend bit and try to subtract.
  always_comb begin
    rem_shift = {rem, TPS_VEC[QUO_W - 1 - int'(cnt)]};
    rem_diff  = rem_shift - {1'b0, dvs};
    fits      = (rem_shift >= {1'b0, dvs});
  end

  // Iteration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        if (cnt == DIV_CNT_W'(QUO_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  // Remainder and quotient.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= '0;
      dvs <= speed_clamped;
    end else if (active) begin
      rem <= fits ? rem_diff[SPEED_W-1:0] : rem_shift[SPEED_W-1:0];
      quo <= {quo[QUO_W-2:0], fits};
    end
  end

  // Saturated period.
  always_comb begin
    rsp.done = done;
    if (quo > QUO_W'(PERIOD_MAX)) begin
      rsp.period = PERIOD_W'(PERIOD_MAX);
    end else begin
      rsp.period = quo[PERIOD_W-1:0];
    end
  end

endmodule

`default_nettype wire

### src/sps_seq.sv
// ----------------------------------------------------------------------------
// sps_seq: command sequencer and motor state
// Holds the motor state and the configuration registers, applies one
// command transaction at a time and drives the period divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sps_seq
  import sps_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  output logic                      cmd_stall,
  input  wire cmd_t                 cmd,
  input  wire logic                 out_free,
  output logic                      res_load,
  output res_t                      res_data,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TABLE_W-1:0]   cfg_data,
  output div_req_t                  div_req,
  input  wire div_rsp_t             div_rsp
);

  ctrl_state_t         state, state_next;
  mode_t               mode_reg, mode_reg_next;
  logic [PHASE_W-1:0]  phase_index, phase_index_next;
  run_t                run_state, run_state_next;
  logic                dir_reg, dir_reg_next;
  logic [COUNT_W-1:0]  steps_left, steps_left_next;
  logic                endless, endless_next;
  logic [PERIOD_W-1:0] step_period, step_period_next;
  logic [MS_W-1:0]     ms_count, ms_count_next;
  logic [COIL_W-1:0]   coil_reg, coil_reg_next;
  logic [TABLE_W-1:0]  phase_table;
  logic [COIL_W-1:0]   off_pattern;

  // Pending turn command while the divider runs.
  logic                pend_endless;
  logic [COUNT_W-1:0]  pend_count;
  logic                pend_dir;

  logic                accept;
  logic                is_turn;
  logic                updated;
  logic [MS_W-1:0]     ms_base;
  logic [PHASE_W-1:0]  delta;

  assign cmd_stall = (state != ST_IDLE) || !out_free;
  assign accept    = cmd_valid && !cmd_stall;
  assign is_turn   = (op_t'(cmd.op) == OP_TURN_COUNTED) || (op_t'(cmd.op) == OP_TURN_ENDLESS);

  // Phase increment of the current step mode.
  always_comb begin
    case (mode_reg)
      MODE_WAVE: delta = PHASE_W'(2);
      MODE_FULL: delta = PHASE_W'(2);
      MODE_HALF: delta = PHASE_W'(1);
      default:   delta = '0;
    endcase
  end

  // Next state, motor state update and result.
  always_comb begin
    state_next       = state;
    mode_reg_next    = mode_reg;
    phase_index_next = phase_index;
    run_state_next   = run_state;
    dir_reg_next     = dir_reg;
    steps_left_next  = steps_left;
    endless_next     = endless;
    step_period_next = step_period;
    ms_count_next    = ms_count;
    coil_reg_next    = coil_reg;
    updated          = 1'b0;
    ms_base          = ms_count;
    res_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.speed    = cmd.speed;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (is_turn) begin
            div_req.start = 1'b1;
            state_next    = ST_DIV;
          end else begin
            res_load = 1'b1;
            case (op_t'(cmd.op))
              OP_TICK: begin
                if (ms_count >= step_period) begin
                  ms_base = '0;
                  updated = 1'b1;
                  case (run_state)
                    RUN_FREE: begin
                      coil_reg_next = off_pattern;
                    end
                    RUN_TORQUE: begin
                      coil_reg_next = pattern_of(phase_table, phase_index);
                    end
                    default: begin
                      // A turn with nothing left holds the coils.
                      if (endless || (steps_left != '0)) begin
                        phase_index_next = dir_reg ? (phase_index - delta)
                                                   : (phase_index + delta);
                        coil_reg_next = pattern_of(phase_table, phase_index_next);
                        if (steps_left != '0) begin
                          steps_left_next = steps_left - 1'b1;
                        end
                      end
                    end
                  endcase
                end
                if (ms_base < MS_W'(PERIOD_MAX)) begin
                  ms_count_next = ms_base + 1'b1;
                end else begin
                  ms_count_next = ms_base;
                end
              end
              OP_SET_MODE: begin
                case (mode_t'(cmd.mode_value))
                  MODE_WAVE: begin
                    mode_reg_next    = MODE_WAVE;
                    phase_index_next = {phase_index[PHASE_W-1:1], 1'b0};
                  end
                  MODE_FULL: begin
                    mode_reg_next    = MODE_FULL;
                    phase_index_next = {phase_index[PHASE_W-1:1], 1'b1};
                  end
                  MODE_HALF: begin
                    mode_reg_next = MODE_HALF;
                  end
                  default: begin
                  end
                endcase
              end
              OP_STOP: begin
                run_state_next = (cmd.mode_value == STOP_FREE) ? RUN_FREE : RUN_TORQUE;
              end
              OP_CONTINUE: begin
                if (run_state != RUN_TURNING) begin
                  dir_reg_next   = cmd.direction;
                  run_state_next = RUN_TURNING;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          step_period_next = div_rsp.period;
          dir_reg_next     = pend_dir;
          run_state_next   = RUN_TURNING;
          endless_next     = pend_endless;
          if (!pend_endless) begin
            steps_left_next = pend_count;
          end
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    res_data.coils         = coil_reg_next;
    res_data.coils_updated = updated;
    res_data.moving        = (run_state_next == RUN_TURNING) &&
                             (endless_next || (steps_left_next != '0));
  end

  // Controller and motor state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      mode_reg    <= MODE_UNSET;
      phase_index <= '0;
      run_state   <= RUN_FREE;
      dir_reg     <= 1'b0;
      steps_left  <= '0;
      endless     <= 1'b0;
      step_period <= PERIOD_W'(PERIOD_RESET);
      ms_count    <= '0;
      coil_reg    <= '0;
    end else begin
      state       <= state_next;
      mode_reg    <= mode_reg_next;
      phase_index <= phase_index_next;
      run_state   <= run_state_next;
      dir_reg     <= dir_reg_next;
      steps_left  <= steps_left_next;
      endless     <= endless_next;
      step_period <= step_period_next;
      ms_count    <= ms_count_next;
      coil_reg    <= coil_reg_next;
    end
  end

  // Turn command held for the divider pass.
  always_ff @(posedge clk) begin
    if (accept && is_turn) begin
      pend_endless <= (op_t'(cmd.op) == OP_TURN_ENDLESS);
      pend_count   <= cmd.step_count;
      pend_dir     <= cmd.direction;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_table <= PHASE_TABLE_RESET;
      off_pattern <= OFF_PATTERN_RESET;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PHASE_TABLE: phase_table <= cfg_data;
        CFG_OFF_PATTERN: off_pattern <= cfg_data[COIL_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### src/stepper_phase_sequencer_top.sv
// Stepper phase sequencer for a four-coil unipolar motor.
// Command channel (cmd_valid, cmd_stall, cmd): each transaction is a 1 ms
// tick or a command (set mode, counted turn, endless turn, stop, continue).
// Result channel (res_valid, res_stall, res): exactly one result per
// command transaction, in order, carrying the coil pattern, whether this
// tick rewrote the coils and whether the motor is moving.
// Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// the phase table (index 0) and the off pattern (index 1); cfg_ready is
// always high and writes are expected only while the block is idle.
// Ticks, mode changes, stops, continues and unused codes give their result
// in the cycle after acceptance. Turn commands wait on the serial divider,
// which works out the step period at one quotient bit per cycle (ten bits
// at 1000 ticks per second), and then on the emit state.
// The block takes one short command per cycle while the receiver does not
// stall; a turn holds the command channel until its result is loaded.
// One transaction is in flight at a time; cmd_stall stays high while a turn
// is divided or emitted or while a result waits on a stalled receiver.
// A stalled result is held in the output register unchanged.
// Synchronous reset restores the register defaults and empties the output.
// ----------------------------------------------------------------------------
// stepper_phase_sequencer_top: top level of the stepper phase sequencer
// Joins the sequencer, the period divider and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stepper_phase_sequencer_top
  import sps_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  output logic                      cmd_stall,
  input  wire cmd_t                 cmd,
  output logic                      res_valid,
  input  wire logic                 res_stall,
  output res_t                      res,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TABLE_W-1:0]   cfg_data
);

  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     out_free;
  logic     res_load;
  res_t     res_data;

  assign cfg_ready = 1'b1;
  assign out_free  = !res_valid || !res_stall;

  sps_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  sps_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .out_free  (out_free),
    .res_load  (res_load),
    .res_data  (res_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .div_req   (div_req),
    .div_rsp   (div_rsp)
  );

  // Result register: loaded when free, held while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_data;
    end
  end

endmodule

`default_nettype wire

### src/sps_checker.sv
// ----------------------------------------------------------------------------
// sps_checker: port-level checks of the stepper phase sequencer
// Watches the top level's command and result channels and is bound to every instance of it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sps_checker
  import sps_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic cmd_valid,
  input wire logic cmd_stall,
  input wire cmd_t cmd,
  input wire logic res_valid,
  input wire logic res_stall,
  input wire res_t res
);

  logic cmd_acc;
  logic turn_acc;

  assign cmd_acc  = cmd_valid && !cmd_stall;
  assign turn_acc = cmd_acc && ((cmd.op == OP_TURN_COUNTED) || (cmd.op == OP_TURN_ENDLESS));

  // A stalled result transaction holds.
  `SPS_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid && $stable(res), "stalled result changed")

  // A command transaction is never taken while a result is stuck.
  `SPS_ASSERT(a_no_overrun, clk, rst, !(cmd_acc && res_valid && res_stall), "command taken over a stalled result")

  // Short commands give their result in the next cycle.
  `SPS_ASSERT_NEXT(a_short_latency, clk, rst, cmd_acc && !turn_acc, res_valid, "short command gave no result")

  // A turn occupies the divider, so the next command waits.
  `SPS_ASSERT_NEXT(a_turn_busy, clk, rst, turn_acc, cmd_stall && !res_valid, "turn did not hold off commands")

  // A turn result shows up and never reports a coil rewrite.
  `SPS_ASSERT_NEXT(a_turn_no_update, clk, rst, $past(turn_acc, 12), res_valid && !res.coils_updated, "bad turn result")

endmodule

bind stepper_phase_sequencer_top sps_checker u_sps_checker (.*);

`default_nettype wire

### tb/tb_stepper_phase_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stepper_phase_sequencer_top: self-checking bench for the phase sequencer
// Drives command transactions and register writes into the sequencer, keeps
// its own cycle-free model of the coil sequencing and compares every result
// transaction with it, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_stepper_phase_sequencer_top;
  import sps_pkg::*;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 9;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int IDLE_LIMIT      = 5000;
  localparam int SETTLE_CYCLES   = 16;
  localparam int TAIL_CYCLES     = 40;

  // Stop selectors and the two op codes the block does not define.
  localparam logic [MODE_W-1:0] STOP_TORQUE     = 2'd1;
  localparam logic [MODE_W-1:0] STOP_TORQUE_ALT = 2'd3;
  localparam logic [OP_W-1:0]   OP_UNUSED_LO    = 3'd6;
  localparam logic [OP_W-1:0]   OP_UNUSED_HI    = 3'd7;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cmd_valid = 1'b0;
  logic                 cmd_stall;
  cmd_t                 cmd       = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  res_t                 res;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TABLE_W-1:0]   cfg_data  = '0;

  stepper_phase_sequencer_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // Model of the sequencer state and its registers.
  logic [TABLE_W-1:0]  phase_tbl_q;
  logic [COIL_W-1:0]   off_q;
  mode_t               mode_q;
  logic [PHASE_W-1:0]  phase_q;
  run_t                run_q;
  logic                dir_q;
  logic [COUNT_W-1:0]  steps_q;
  logic                endless_q;
  logic [PERIOD_W-1:0] period_q;
  logic [MS_W-1:0]     ms_q;
  logic [COIL_W-1:0]   coil_q;

  res_t coil_results_due[$];
  res_t coil_result_now;

  int mismatches     = 0;
  int items_sent     = 0;
  int useful_items   = 0;
  int results_seen   = 0;
  int coil_rewrites  = 0;
  int reg_writes     = 0;
  int burst_left     = 0;
  int idle_cycles    = 0;

  // Receiver stall pattern and the long hold-off request.
  logic       hold_request = 1'b0;
  logic       hold_seen    = 1'b0;
  int         hold_left    = 0;
  logic [7:0] stall_phase  = '0;
  int         stall_style  = 0;

  task automatic reset_model();
    phase_tbl_q = PHASE_TABLE_RESET;
    off_q       = OFF_PATTERN_RESET;
    mode_q      = MODE_UNSET;
    phase_q     = '0;
    run_q       = RUN_FREE;
    dir_q       = 1'b0;
    steps_q     = '0;
    endless_q   = 1'b0;
    period_q    = PERIOD_W'(PERIOD_RESET);
    ms_q        = '0;
    coil_q      = '0;
  endtask

  // Step period in ticks for a requested speed, with the speed clamped.
  function automatic logic [PERIOD_W-1:0] ticks_per_step(logic [SPEED_W-1:0] spd);
    int s;
    int p;
    s = spd;
    if (s < 1) s = 1;
    if (s > SPEED_MAX) s = SPEED_MAX;
    p = TICKS_PER_SECOND / s;
    if (p > PERIOD_MAX) p = PERIOD_MAX;
    return PERIOD_W'(p);
  endfunction

  // Applies one command transaction to the model and returns the coil result.
  function automatic res_t sequence_coils(cmd_t c);
    res_t               r;
    logic               upd;
    logic [PHASE_W-1:0] delta;
    upd = 1'b0;
    case (c.op)
      OP_TICK: begin
        if (ms_q >= period_q) begin
          ms_q = '0;
          upd  = 1'b1;
          case (run_q)
            RUN_FREE:   coil_q = off_q;
            RUN_TORQUE: coil_q = COIL_W'(phase_tbl_q >> (COIL_W * phase_q));
            default: begin
              // Turning with nothing left keeps the coils as they are.
              if (endless_q || steps_q != '0) begin
                case (mode_q)
                  MODE_HALF:  delta = 1;
                  MODE_UNSET: delta = 0;
                  default:    delta = 2;
                endcase
                phase_q = dir_q ? phase_q - delta : phase_q + delta;
                coil_q  = COIL_W'(phase_tbl_q >> (COIL_W * phase_q));
                if (steps_q != '0) steps_q = steps_q - 1'b1;
              end
            end
          endcase
        end
        if (ms_q < PERIOD_MAX) ms_q = ms_q + 1'b1;
      end
      OP_SET_MODE: begin
        // Wave sits on even phases and full on odd ones.
        if (c.mode_value == MODE_WAVE) begin
          mode_q = MODE_WAVE;
          if (phase_q[0]) phase_q = phase_q - 1'b1;
        end else if (c.mode_value == MODE_FULL) begin
          mode_q = MODE_FULL;
          if (!phase_q[0]) phase_q = phase_q + 1'b1;
        end else if (c.mode_value == MODE_HALF) begin
          mode_q = MODE_HALF;
        end
      end
      OP_TURN_COUNTED: begin
        dir_q     = c.direction;
        steps_q   = c.step_count;
        endless_q = 1'b0;
        period_q  = ticks_per_step(c.speed);
        run_q     = RUN_TURNING;
      end
      OP_TURN_ENDLESS: begin
        endless_q = 1'b1;
        period_q  = ticks_per_step(c.speed);
        dir_q     = c.direction;
        run_q     = RUN_TURNING;
      end
      OP_STOP: begin
        run_q = (c.mode_value == STOP_FREE) ? RUN_FREE : RUN_TORQUE;
      end
      OP_CONTINUE: begin
        if (run_q != RUN_TURNING) begin
          dir_q = c.direction;
          run_q = RUN_TURNING;
        end
      end
      default: ;
    endcase
    r.coils         = coil_q;
    r.coils_updated = upd;
    r.moving        = (run_q == RUN_TURNING) && (endless_q || steps_q != '0);
    return r;
  endfunction

  function automatic cmd_t make_cmd(logic [OP_W-1:0] op, logic [MODE_W-1:0] mv,
                                    logic [COUNT_W-1:0] cnt, logic [SPEED_W-1:0] spd,
                                    logic dir);
    cmd_t c;
    c.op         = op;
    c.mode_value = mv;
    c.step_count = cnt;
    c.speed      = spd;
    c.direction  = dir;
    return c;
  endfunction

  function automatic cmd_t random_command();
    cmd_t c;
    c.op         = OP_W'($urandom_range(0, 7));
    c.mode_value = MODE_W'($urandom_range(0, 3));
    c.step_count = COUNT_W'($urandom);
    c.speed      = SPEED_W'($urandom);
    c.direction  = 1'($urandom);
    return c;
  endfunction

  // Mostly fast speeds so that step periods end within a short tick run.
  function automatic logic [SPEED_W-1:0] pick_speed();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 12) return SPEED_W'($urandom_range(250, SPEED_MAX));
    if (roll < 17) return SPEED_W'($urandom_range(20, 249));
    if (roll < 19) return SPEED_W'($urandom);
    return ($urandom_range(0, 1) == 0) ? '0 : '1;
  endfunction

  // Offers one command transaction and waits for it to be taken. The sender
  // works in bursts; valid is dropped only when a gap follows.
  task automatic send_command(cmd_t c);
    int gap;
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (cmd_stall !== 1'b0);
    coil_results_due.push_back(sequence_coils(c));
    items_sent++;
    if (c.op <= OP_CONTINUE && !(c.op == OP_SET_MODE && c.mode_value == MODE_UNSET))
      useful_items++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(0, 10);
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_ticks(int n);
    cmd_t c;
    repeat (n) begin
      c    = random_command();
      c.op = OP_TICK;
      send_command(c);
    end
  endtask

  // Waits until every result has come back and the block has gone quiet.
  task automatic settle_block();
    cmd_valid <= 1'b0;
    while (coil_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(cfg_idx_t idx, logic [TABLE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == CFG_PHASE_TABLE) phase_tbl_q = data;
    else off_q = data[COIL_W-1:0];
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [TABLE_W-1:0] tbl, logic [TABLE_W-1:0] off);
    settle_block();
    write_register(CFG_PHASE_TABLE, tbl);
    write_register(CFG_OFF_PATTERN, off);
  endtask

  // A well-formed turn: optional mode change, a turn, a tick run, and now
  // and then a stop or a resume with ticks after it.
  task automatic run_turn_sequence();
    cmd_t c;
    c = random_command();
    if ($urandom_range(0, 2) == 0) begin
      c.op = OP_SET_MODE;
      send_command(c);
      c = random_command();
    end
    if ($urandom_range(0, 3) == 0) begin
      c.op = OP_TURN_ENDLESS;
    end else begin
      c.op = OP_TURN_COUNTED;
      case ($urandom_range(0, 9))
        0:       c.step_count = COUNT_W'($urandom);
        1, 2:    c.step_count = COUNT_W'($urandom_range(0, 100));
        default: c.step_count = COUNT_W'($urandom_range(1, 10));
      endcase
    end
    c.speed = pick_speed();
    send_command(c);
    send_ticks($urandom_range(4, 30));
    if ($urandom_range(0, 2) == 0) begin
      c    = random_command();
      c.op = OP_STOP;
      send_command(c);
      send_ticks($urandom_range(2, 10));
    end
    if ($urandom_range(0, 2) == 0) begin
      c    = random_command();
      c.op = OP_CONTINUE;
      send_command(c);
      send_ticks($urandom_range(2, 15));
    end
  endtask

  task automatic random_traffic(int n);
    int start;
    start = useful_items;
    while (useful_items - start < n) begin
      if ($urandom_range(0, 6) == 0) send_command(random_command());
      else run_turn_sequence();
    end
  endtask

  // Every op, the mode alignment rules, the unset mode, idle turning, the
  // reverse wrap below phase zero and the ignored codes, from reset.
  task automatic test_directed_commands();
    send_command(make_cmd(OP_TICK, '0, '0, '0, 1'b0));
    send_command(make_cmd(OP_SET_MODE, MODE_UNSET, '0, '0, 1'b0));
    send_command(make_cmd(OP_TURN_COUNTED, '0, 15'd2, SPEED_W'(SPEED_MAX), 1'b0));
    send_ticks(4);
    send_command(make_cmd(OP_SET_MODE, MODE_FULL, '0, '0, 1'b0));
    send_command(make_cmd(OP_SET_MODE, MODE_WAVE, '0, '0, 1'b0));
    send_command(make_cmd(OP_SET_MODE, MODE_HALF, '0, '0, 1'b0));
    send_command(make_cmd(OP_TURN_COUNTED, '0, '1, '1, 1'b1));
    send_ticks(2);
    send_command(make_cmd(OP_STOP, STOP_TORQUE, '0, '0, 1'b0));
    send_ticks(2);
    send_command(make_cmd(OP_STOP, STOP_FREE, '0, '0, 1'b0));
    send_ticks(1);
    send_command(make_cmd(OP_CONTINUE, '0, '0, '0, 1'b1));
    send_command(make_cmd(OP_CONTINUE, '0, '0, '0, 1'b0));
    send_ticks(1);
    send_command(make_cmd(OP_TURN_ENDLESS, '0, '0, '0, 1'b0));
    send_command(make_cmd(OP_UNUSED_LO, '1, '1, '1, 1'b1));
    send_command(make_cmd(OP_UNUSED_HI, '1, '1, '1, 1'b1));
    send_command(make_cmd(OP_STOP, STOP_TORQUE_ALT, '0, '0, 1'b0));
    send_ticks(1);
  endtask

  // Register extremes, each followed by a short stretch of traffic.
  task automatic test_config_extremes();
    configure('0, TABLE_W'(4'hF));
    random_traffic(40);
    configure('1, '0);
    random_traffic(40);
    configure(TABLE_W'($urandom), TABLE_W'($urandom));
    random_traffic(40);
    configure(PHASE_TABLE_RESET, TABLE_W'(OFF_PATTERN_RESET));
    random_traffic(40);
  endtask

  // The receiver holds off while commands keep coming, so the block backs up.
  task automatic test_receiver_hold_off();
    int start;
    start = useful_items;
    hold_request <= ~hold_request;
    while (useful_items - start < 30) run_turn_sequence();
  endtask

  task automatic test_random_traffic();
    repeat (4) begin
      configure(TABLE_W'($urandom), TABLE_W'($urandom));
      random_traffic(250);
    end
  endtask

  // Receiver: a stall style of its own, redrawn at random, or a long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      res_stall   <= 1'b0;
      hold_left   <= 0;
      hold_seen   <= hold_request;
      stall_phase <= '0;
      stall_style <= 0;
    end else begin
      stall_phase <= stall_phase + 1'b1;
      if (stall_phase[5:0] == '0) stall_style <= $urandom_range(0, 3);
      if (hold_seen != hold_request) begin
        hold_seen <= hold_request;
        hold_left <= HOLD_OFF_CYCLES;
        res_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        res_stall <= 1'b1;
      end else begin
        case (stall_style)
          0:       res_stall <= 1'b0;
          1:       res_stall <= ($urandom_range(0, 2) == 0);
          2:       res_stall <= (stall_phase[1:0] == 2'b11);
          default: res_stall <= stall_phase[3];
        endcase
      end
    end
  end

  // Each result transaction is compared with the oldest expected coil result.
  always @(posedge clk) begin
    if (!rst && res_valid === 1'b1 && res_stall == 1'b0) begin
      results_seen++;
      if (coil_results_due.size() == 0) begin
        $error("result transaction with nothing expected: coils %0h updated %0b moving %0b",
               res.coils, res.coils_updated, res.moving);
        mismatches++;
      end else begin
        coil_result_now = coil_results_due.pop_front();
        if (res.coils_updated === 1'b1) coil_rewrites++;
        if (res.coils !== coil_result_now.coils) begin
          $error("coils: expected %0h, got %0h", coil_result_now.coils, res.coils);
          mismatches++;
        end
        if (res.coils_updated !== coil_result_now.coils_updated) begin
          $error("coils_updated: expected %0b, got %0b",
                 coil_result_now.coils_updated, res.coils_updated);
          mismatches++;
        end
        if (res.moving !== coil_result_now.moving) begin
          $error("moving: expected %0b, got %0b", coil_result_now.moving, res.moving);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles in which no transaction of any kind is taken.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)
                 || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("stepper_phase_sequencer_top test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    reset_model();

    test_directed_commands();
    test_config_extremes();
    test_receiver_hold_off();
    test_random_traffic();

    settle_block();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d command transactions (%0d effective) and %0d results, %0d of them coil rewrites.",
             items_sent, useful_items, results_seen, coil_rewrites);
    $display("Register writes: %0d over several table and off-pattern settings, with one long receiver hold-off.",
             reg_writes);
    if (mismatches == 0 && coil_results_due.size() == 0) begin
      $display("stepper_phase_sequencer_top test passed");
    end else begin
      $display("stepper_phase_sequencer_top test failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/sps_pkg.sv
src/sps_div.sv
src/sps_seq.sv
src/stepper_phase_sequencer_top.sv
src/sps_checker.sv
tb/tb_stepper_phase_sequencer_top.sv
